@@ hdl/i2crm_pkg.sv @@
// i2crm_pkg: shared widths, bus sequencer state codes and constants for the
// I2C register master. No dependencies.
package i2crm_pkg;

	localparam int StateW = 5;
	localparam int CountW = 16;

	localparam logic [StateW-1:0] ST_IDLE      = 5'd0;
	localparam logic [StateW-1:0] ST_START     = 5'd1;
	localparam logic [StateW-1:0] ST_ADDRW     = 5'd2;
	localparam logic [StateW-1:0] ST_ADDRW_ACK = 5'd3;
	localparam logic [StateW-1:0] ST_REG       = 5'd4;
	localparam logic [StateW-1:0] ST_REG_ACK   = 5'd5;
	localparam logic [StateW-1:0] ST_DATA      = 5'd6;
	localparam logic [StateW-1:0] ST_DATA_ACK  = 5'd7;
	localparam logic [StateW-1:0] ST_ADDRR     = 5'd8;
	localparam logic [StateW-1:0] ST_ADDRR_ACK = 5'd9;
	localparam logic [StateW-1:0] ST_WAIT      = 5'd10;
	localparam logic [StateW-1:0] ST_RESTART   = 5'd11;
	localparam logic [StateW-1:0] ST_RX        = 5'd12;
	localparam logic [StateW-1:0] ST_RXACK     = 5'd13;
	localparam logic [StateW-1:0] ST_STOP      = 5'd14;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_SUPPLY = 2'd3;

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;
	localparam logic [1:0] PH_3 = 2'd3;

	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

endpackage

@@ hdl/i2c_register_master.sv @@
// i2c_register_master: bit-banged I2C master for register reads and writes.
// Depends on i2crm_pkg.
//
// Usage:
//   Input words on s_* carry a command kind in s_tuser (tick, begin write,
//   begin read, supply write byte) plus SDA level and command fields.
//   Only tick words move the bus sequencer; one tick is one count of the
//   quarter-bit phase timer, whose length (phase_ticks) the user must write
//   on cfg_* only while the block is idle (not enforced by the block). cfg_ready is always high.
//   Every input word yields exactly one output word on m_*: line drive
//   levels, busy, data request, done and any received byte (m_tuser flags a
//   valid byte, m_tlast marks the final byte of a read).
// Latency and throughput:
//   One word per cycle unless m_tready stalls. The result word appears on
//   m_* the cycle after the input word is taken; all sequencer work is one
//   combinational step between the state registers and the output register.
// Stall: s_tready is high while the output register is empty or being
//   drained; a held m_tready blocks only new input, not the held result.
// Reset: arst_n clears the sequencer to idle with SCL and SDA released,
//   phase_ticks to 1 and empties the output register.
module i2c_register_master
	import i2crm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,    // phase_ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,     // sda_in, device_addr, register_addr, byte_count, write_data
	input  logic [1:0]  s_tuser,     // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // scl_out, sda_out, busy_res, data_request, read_data, done_res, pad
	output logic        m_tuser,     // read_valid
	output logic        m_tlast      // read_last
);

	logic [7:0]        phase_ticks_q;
	logic [StateW-1:0] state_q, state_d;
	logic [1:0]        phase_q, phase_d;
	logic [7:0]        tick_q, tick_d;
	logic [2:0]        bit_q, bit_d;
	logic [7:0]        shift_q, shift_d;
	logic [CountW-1:0] left_q, left_d;
	logic [6:0]        slave_q, slave_d;
	logic [7:0]        reg_q, reg_d;
	logic              rd_q, rd_d;
	logic [7:0]        pend_q, pend_d;
	logic              pend_vld_q, pend_vld_d;
	logic              scl_q, scl_d;
	logic              sda_q, sda_d;

	logic              rv, rlast, done;
	logic [7:0]        rdat;
	logic [7:0]        rx_shift;
	logic              adv;
	logic              accept;

	logic              sda_in;
	logic [6:0]        device_addr;
	logic [7:0]        register_addr;
	logic [15:0]       byte_count;
	logic [7:0]        write_data;
	logic [1:0]        mode;

	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	assign sda_in        = s_tdata[0];
	assign device_addr   = s_tdata[7:1];
	assign register_addr = s_tdata[15:8];
	assign byte_count    = s_tdata[31:16];
	assign write_data    = s_tdata[39:32];
	assign mode          = s_tuser;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign rx_shift  = {shift_q[6:0], sda_in};

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		tick_d     = tick_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		left_d     = left_q;
		slave_d    = slave_q;
		reg_d      = reg_q;
		rd_d       = rd_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		rv         = 1'b0;
		rdat       = 8'd0;
		rlast      = 1'b0;
		done       = 1'b0;
		adv        = 1'b1;

		unique case (mode)
			MODE_WRITE, MODE_READ: begin
				if (state_q == ST_IDLE) begin
					slave_d    = device_addr;
					reg_d      = register_addr;
					left_d     = (byte_count != '0) ? byte_count : CountW'(1);
					rd_d       = (mode == MODE_READ);
					pend_vld_d = 1'b0;
					state_d    = ST_START;
					phase_d    = PH_0;
					tick_d     = 8'd0;
					bit_d      = 3'd0;
				end
			end
			MODE_SUPPLY: begin
				if (state_q != ST_IDLE && !rd_q) begin
					pend_d     = write_data;
					pend_vld_d = 1'b1;
				end
			end
			default: begin
				if (state_q == ST_WAIT) begin
					if (pend_vld_q) begin
						pend_vld_d = 1'b0;
						if (left_q != '0)
							left_d = left_q - CountW'(1);
						state_d = ST_DATA;
						shift_d = pend_q;
						bit_d   = 3'd0;
						phase_d = PH_0;
						tick_d  = 8'd0;
					end
				end else if (state_q != ST_IDLE) begin
					if ({1'b0, tick_q} + 9'd1 < {1'b0, phase_ticks_q}) begin
						tick_d = tick_q + 8'd1;
					end else begin
						tick_d = 8'd0;
						unique case (state_q)
							ST_START, ST_RESTART: begin
								unique case (phase_q)
									PH_0: sda_d = 1'b1;
									PH_1: scl_d = 1'b1;
									PH_2: sda_d = 1'b0;
									default: begin
										scl_d = 1'b0;
										bit_d = 3'd0;
										if (state_q == ST_START) begin
											state_d = ST_ADDRW;
											shift_d = {slave_q, 1'b0};
										end else begin
											state_d = ST_ADDRR;
											shift_d = {slave_q, 1'b1};
										end
									end
								endcase
							end
							ST_ADDRW, ST_REG, ST_DATA, ST_ADDRR: begin
								unique case (phase_q)
									PH_0: sda_d = |(shift_q & MSB_MASK);
									PH_1: scl_d = 1'b1;
									PH_2: scl_d = 1'b0;
									default: begin
										shift_d = {shift_q[6:0], 1'b0};
										if (bit_q == 3'd7) begin
											bit_d   = 3'd0;
											state_d = state_q + StateW'(1);
										end else begin
											bit_d = bit_q + 3'd1;
										end
									end
								endcase
							end
							ST_ADDRW_ACK, ST_REG_ACK, ST_DATA_ACK, ST_ADDRR_ACK: begin
								unique case (phase_q)
									PH_0: sda_d = 1'b1;
									PH_1: scl_d = 1'b1;
									PH_2: begin
										if (sda_in)
											adv = 1'b0;
										else
											scl_d = 1'b0;
									end
									default: begin
										priority if (state_q == ST_ADDRW_ACK) begin
											state_d = ST_REG;
											shift_d = reg_q;
											bit_d   = 3'd0;
										end else if (state_q == ST_REG_ACK) begin
											state_d = rd_q ? ST_RESTART : ST_WAIT;
										end else if (state_q == ST_DATA_ACK) begin
											state_d = (left_q != '0) ? ST_WAIT : ST_STOP;
										end else begin
											state_d = ST_RX;
											shift_d = 8'd0;
											bit_d   = 3'd0;
										end
									end
								endcase
							end
							ST_RX: begin
								unique case (phase_q)
									PH_0: sda_d = 1'b1;
									PH_1: scl_d = 1'b1;
									PH_2: begin
										shift_d = rx_shift;
										scl_d   = 1'b0;
										if (bit_q == 3'd7) begin
											rv    = 1'b1;
											rdat  = rx_shift;
											rlast = (left_q == CountW'(1));
										end
									end
									default: begin
										if (bit_q == 3'd7) begin
											bit_d   = 3'd0;
											state_d = ST_RXACK;
										end else begin
											bit_d = bit_q + 3'd1;
										end
									end
								endcase
							end
							ST_RXACK: begin
								unique case (phase_q)
									PH_0: sda_d = (left_q <= CountW'(1));
									PH_1: scl_d = 1'b1;
									PH_2: scl_d = 1'b0;
									default: begin
										sda_d = 1'b1;
										// last byte when count is 0 or 1 before decrement
										if (left_q <= CountW'(1)) begin
											left_d  = '0;
											state_d = ST_STOP;
										end else begin
											left_d  = left_q - CountW'(1);
											state_d = ST_RX;
											shift_d = 8'd0;
										end
									end
								endcase
							end
							ST_STOP: begin
								unique case (phase_q)
									PH_0: sda_d = 1'b0;
									PH_1: scl_d = 1'b1;
									PH_2: ;
									default: begin
										sda_d   = 1'b1;
										done    = 1'b1;
										state_d = ST_IDLE;
									end
								endcase
							end
							default: begin
								state_d = ST_IDLE;
								scl_d   = 1'b1;
								sda_d   = 1'b1;
							end
						endcase
						if (adv)
							phase_d = phase_q + 2'd1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_valid) begin
			phase_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_0;
			tick_q     <= 8'd0;
			bit_q      <= 3'd0;
			shift_q    <= 8'd0;
			left_q     <= '0;
			slave_q    <= 7'd0;
			reg_q      <= 8'd0;
			rd_q       <= 1'b0;
			pend_vld_q <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
		end else if (accept) begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			bit_q      <= bit_d;
			shift_q    <= shift_d;
			left_q     <= left_d;
			slave_q    <= slave_d;
			reg_q      <= reg_d;
			rd_q       <= rd_d;
			pend_vld_q <= pend_vld_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
		end
	end

	// pending byte is gated by its valid flag, no reset
	always_ff @(posedge clk) begin
		if (accept)
			pend_q <= pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {3'd0, done, rdat,
				(state_d == ST_WAIT) && !pend_vld_d,
				state_d != ST_IDLE, sda_d, scl_d};
			m_tuser_q <= rv;
			m_tlast_q <= rlast;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ tb/i2c_register_master_tb.sv @@
// i2c_register_master_tb: self-checking bench for the I2C register master.
// Streams tick/command words into s_*, predicts every m_* word with a local
// bus sequencer model and compares field by field. Depends on i2crm_pkg.
`timescale 1ns / 1ps

module i2c_register_master_tb;
	import i2crm_pkg::*;

	typedef struct {
		logic [1:0]  mode;
		logic        sda;
		logic [6:0]  dev_addr;
		logic [7:0]  reg_addr;
		logic [15:0] count;
		logic [7:0]  wdata;
	} bus_cmd_t;

	typedef struct packed {
		logic       scl;
		logic       sda_drv;
		logic       busy;
		logic       data_req;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       rx_last;
		logic       stop_done;
	} bus_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = 40'd0;  // sda_in, device_addr, register_addr, byte_count, write_data
	logic [1:0]  s_tuser = 2'd0;   // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // scl_out, sda_out, busy_res, data_request, read_data, done_res, pad
	logic        m_tuser;          // read_valid
	logic        m_tlast;          // read_last

	bus_cmd_t    cmd_q[$];
	bus_view_t   bus_view_q[$];
	bus_cmd_t    held_cmd;
	int unsigned stall_pct = 31;
	int          mismatches = 0;

	// predicted sequencer state
	logic [7:0]  ptick = PHASE_TICKS_RST;
	logic [4:0]  bus_st = ST_IDLE;
	logic [1:0]  phase = PH_0;
	logic [7:0]  tick_cnt = 8'd0;
	logic [2:0]  bit_no = 3'd0;
	logic [7:0]  shreg = 8'd0;
	logic [15:0] left = 16'd0;
	logic [6:0]  dev_hold = 7'd0;
	logic [7:0]  reg_hold = 8'd0;
	logic        rd_dir = 1'b0;
	logic [7:0]  next_byte = 8'd0;
	logic        byte_ready = 1'b0;
	logic        scl_lv = 1'b1;
	logic        sda_lv = 1'b1;

	i2c_register_master i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic bus_view_t advance_bus(bus_cmd_t c);
		bus_view_t r;
		logic      go;
		r = '0;
		go = 1'b1;
		case (c.mode)
			MODE_WRITE, MODE_READ: begin
				if (bus_st == ST_IDLE) begin
					dev_hold = c.dev_addr;
					reg_hold = c.reg_addr;
					left = (c.count != 16'd0) ? c.count : 16'd1;
					rd_dir = (c.mode == MODE_READ);
					byte_ready = 1'b0;
					bus_st = ST_START;
					phase = PH_0;
					tick_cnt = 8'd0;
					bit_no = 3'd0;
				end
			end
			MODE_SUPPLY: begin
				if (bus_st != ST_IDLE && !rd_dir) begin
					next_byte = c.wdata;
					byte_ready = 1'b1;
				end
			end
			default: begin
				if (bus_st == ST_WAIT) begin
					if (byte_ready) begin
						byte_ready = 1'b0;
						if (left != 16'd0) left = left - 16'd1;
						bus_st = ST_DATA;
						shreg = next_byte;
						bit_no = 3'd0;
						phase = PH_0;
						tick_cnt = 8'd0;
					end
				end else if (bus_st != ST_IDLE) begin
					if ({1'b0, tick_cnt} + 9'd1 < {1'b0, ptick}) begin
						tick_cnt = tick_cnt + 8'd1;
					end else begin
						tick_cnt = 8'd0;
						case (bus_st)
							ST_START, ST_RESTART: begin
								case (phase)
									PH_0: sda_lv = 1'b1;
									PH_1: scl_lv = 1'b1;
									PH_2: sda_lv = 1'b0;
									default: begin
										scl_lv = 1'b0;
										shreg = {dev_hold, bus_st == ST_RESTART};
										bus_st = (bus_st == ST_START) ? ST_ADDRW : ST_ADDRR;
										bit_no = 3'd0;
									end
								endcase
							end
							ST_ADDRW, ST_REG, ST_DATA, ST_ADDRR: begin
								case (phase)
									PH_0: sda_lv = shreg[7];
									PH_1: scl_lv = 1'b1;
									PH_2: scl_lv = 1'b0;
									default: begin
										shreg = {shreg[6:0], 1'b0};
										if (bit_no == 3'd7) begin
											bit_no = 3'd0;
											bus_st = bus_st + 5'd1;
										end else begin
											bit_no = bit_no + 3'd1;
										end
									end
								endcase
							end
							ST_ADDRW_ACK, ST_REG_ACK, ST_DATA_ACK, ST_ADDRR_ACK: begin
								case (phase)
									PH_0: sda_lv = 1'b1;
									PH_1: scl_lv = 1'b1;
									PH_2: begin
										if (c.sda) go = 1'b0;
										else scl_lv = 1'b0;
									end
									default: begin
										if (bus_st == ST_ADDRW_ACK) begin
											bus_st = ST_REG;
											shreg = reg_hold;
											bit_no = 3'd0;
										end else if (bus_st == ST_REG_ACK) begin
											bus_st = rd_dir ? ST_RESTART : ST_WAIT;
										end else if (bus_st == ST_DATA_ACK) begin
											bus_st = (left != 16'd0) ? ST_WAIT : ST_STOP;
										end else begin
											bus_st = ST_RX;
											shreg = 8'd0;
											bit_no = 3'd0;
										end
									end
								endcase
							end
							ST_RX: begin
								case (phase)
									PH_0: sda_lv = 1'b1;
									PH_1: scl_lv = 1'b1;
									PH_2: begin
										shreg = {shreg[6:0], c.sda};
										scl_lv = 1'b0;
										if (bit_no == 3'd7) begin
											r.rx_valid = 1'b1;
											r.rx_byte = shreg;
											r.rx_last = (left == 16'd1);
										end
									end
									default: begin
										if (bit_no == 3'd7) begin
											bit_no = 3'd0;
											bus_st = ST_RXACK;
										end else begin
											bit_no = bit_no + 3'd1;
										end
									end
								endcase
							end
							ST_RXACK: begin
								case (phase)
									PH_0: sda_lv = (left <= 16'd1);
									PH_1: scl_lv = 1'b1;
									PH_2: scl_lv = 1'b0;
									default: begin
										sda_lv = 1'b1;
										if (left != 16'd0) left = left - 16'd1;
										if (left == 16'd0) begin
											bus_st = ST_STOP;
										end else begin
											bus_st = ST_RX;
											shreg = 8'd0;
										end
									end
								endcase
							end
							ST_STOP: begin
								case (phase)
									PH_0: sda_lv = 1'b0;
									PH_1: scl_lv = 1'b1;
									PH_3: begin
										sda_lv = 1'b1;
										r.stop_done = 1'b1;
										bus_st = ST_IDLE;
									end
									default: ;
								endcase
							end
							default: begin
								bus_st = ST_IDLE;
								scl_lv = 1'b1;
								sda_lv = 1'b1;
							end
						endcase
						if (go) phase = phase + 2'd1;
					end
				end
			end
		endcase
		r.scl = scl_lv;
		r.sda_drv = sda_lv;
		r.busy = (bus_st != ST_IDLE);
		r.data_req = (bus_st == ST_WAIT) && !byte_ready;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				bus_view_q.push_back(advance_bus(held_cmd));
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= stall_pct) begin
					held_cmd = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {held_cmd.wdata, held_cmd.count, held_cmd.reg_addr,
						held_cmd.dev_addr, held_cmd.sda};
					s_tuser <= held_cmd.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bus_view_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (bus_view_q.size() == 0) begin
					$error("output word with no prediction pending");
					mismatches++;
				end else begin
					want = bus_view_q.pop_front();
					check_field("scl_out", 8'(want.scl), 8'(m_tdata[0]));
					check_field("sda_out", 8'(want.sda_drv), 8'(m_tdata[1]));
					check_field("busy_res", 8'(want.busy), 8'(m_tdata[2]));
					check_field("data_request", 8'(want.data_req), 8'(m_tdata[3]));
					check_field("read_data", want.rx_byte, m_tdata[11:4]);
					check_field("done_res", 8'(want.stop_done), 8'(m_tdata[12]));
					check_field("read_valid", 8'(want.rx_valid), 8'(m_tuser));
					check_field("read_last", 8'(want.rx_last), 8'(m_tlast));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic queue_cmd(logic [1:0] m, logic s, logic [6:0] d, logic [7:0] ra,
		logic [15:0] n, logic [7:0] wd);
		bus_cmd_t c;
		c.mode = m;
		c.sda = s;
		c.dev_addr = d;
		c.reg_addr = ra;
		c.count = n;
		c.wdata = wd;
		cmd_q.push_back(c);
	endtask

	task automatic queue_ticks(int n, int high_pct);
		for (int i = 0; i < n; i++)
			queue_cmd(MODE_TICK, $urandom_range(0, 99) < high_pct, 7'($urandom),
				8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic queue_random(int n);
		int unsigned pick;
		logic [1:0]  m;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) m = MODE_TICK;
			else if (pick < 88) m = MODE_SUPPLY;
			else if (pick < 94) m = MODE_WRITE;
			else m = MODE_READ;
			queue_cmd(m, $urandom_range(0, 99) < 30, 7'($urandom), 8'($urandom),
				(m == MODE_WRITE || m == MODE_READ) ? 16'($urandom_range(0, 4)) : 16'($urandom),
				8'($urandom));
		end
	endtask

	// wait until every word is taken and every prediction is matched
	task automatic settle();
		while (cmd_q.size() != 0 || s_tvalid || bus_view_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_phase_ticks(logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ptick = v;
	endtask

	initial begin
		int guard;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_phase_ticks(8'd1);

		// idle commands, zero count, ignored begin, overwritten pending byte
		queue_ticks(2, 50);
		queue_cmd(MODE_SUPPLY, 1'b1, 7'h00, 8'h00, 16'h0000, 8'hFF);
		queue_cmd(MODE_WRITE, 1'b0, 7'h7F, 8'hFF, 16'h0000, 8'h00);
		queue_cmd(MODE_READ, 1'b1, 7'h00, 8'h00, 16'hFFFF, 8'h00);
		queue_cmd(MODE_SUPPLY, 1'b0, 7'h00, 8'h00, 16'h0000, 8'h00);
		queue_cmd(MODE_SUPPLY, 1'b0, 7'h00, 8'h00, 16'h0000, 8'hA5);
		queue_ticks(130, 0);
		// write stalls on data wait
		queue_cmd(MODE_WRITE, 1'b0, 7'h55, 8'h0F, 16'd2, 8'h00);
		queue_ticks(90, 0);
		queue_cmd(MODE_SUPPLY, 1'b0, 7'h00, 8'h00, 16'h0000, 8'h00);
		queue_ticks(45, 0);
		queue_cmd(MODE_SUPPLY, 1'b0, 7'h00, 8'h00, 16'h0000, 8'hFF);
		queue_ticks(50, 0);
		// read with missing ACK, supply ignored while reading
		queue_cmd(MODE_READ, 1'b0, 7'h2A, 8'h80, 16'd2, 8'h00);
		queue_cmd(MODE_SUPPLY, 1'b0, 7'h00, 8'h00, 16'h0000, 8'h5A);
		queue_ticks(40, 100);
		queue_ticks(80, 0);
		queue_ticks(36, 100);
		queue_ticks(70, 50);
		settle();

		stall_pct = 0;
		queue_random(90);
		settle();
		stall_pct = 31;

		write_phase_ticks(8'd2);
		queue_random(90);
		settle();

		// slowest phase, then shortened mid-transaction
		write_phase_ticks(8'd255);
		queue_cmd(MODE_WRITE, 1'b0, 7'($urandom), 8'($urandom), 16'd1, 8'h00);
		queue_random(130);
		settle();
		write_phase_ticks(8'd1);
		queue_random(70);
		settle();

		write_phase_ticks(8'd3);
		queue_random(70);
		settle();

		guard = 0;
		while (bus_st != ST_IDLE && guard < 300) begin
			for (int i = 0; i < 40; i++)
				queue_cmd((i % 8 == 7) ? MODE_SUPPLY : MODE_TICK, 1'b0, 7'($urandom),
					8'($urandom), 16'($urandom), 8'($urandom));
			settle();
			guard++;
		end

		queue_cmd(MODE_READ, 1'b0, 7'($urandom), 8'($urandom), 16'hFFFF, 8'($urandom));
		queue_ticks(60, 30);
		settle();

		if (mismatches == 0)
			$display("** i2c_register_master: PASSED **");
		else
			$display("** i2c_register_master: FAILED **");
		$finish;
	end

	initial begin
		#3ms;
		$display("** i2c_register_master: FAILED **");
		$finish;
	end

endmodule

@@ i2c_register_master.f @@
hdl/i2crm_pkg.sv
hdl/i2c_register_master.sv
tb/i2c_register_master_tb.sv
